// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the crop resize RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, suspended while the synchronous reset is low.
`define CRTP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CRTP_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/crtp_pkg.sv =====
// Package for the crop resize block: field widths, codes, state and
// controller/datapath command types. Depends on nothing.
package crtp_pkg;

  localparam int DIM_W       = 10;               // configured dimensions
  localparam int COORD_W     = 9;                // target coordinates
  localparam int CHAN_W      = 8;                // loaded color byte
  localparam int LEVEL_W     = 16;               // Q0.16 channel level
  localparam int PIX_W       = 3 * CHAN_W;       // packed R,G,B entry
  localparam int PLANE_W     = 18;               // plane index field
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int NUM_W       = COORD_W + 1 + DIM_W;  // (2t+1)*src
  localparam int DEN_W       = DIM_W + 1;            // 2*tgt
  localparam int DIV_CNT_W   = $clog2(NUM_W + 1);
  localparam int PROD_W      = 2 * DIM_W;
  localparam int IDX_W       = COORD_W + DIM_W + 1;

  localparam int MAX_DIMENSION_DEF   = 512;
  localparam int MAX_CROP_PIXELS_DEF = 65536;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CROP_W   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_H   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_W = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_H = 2'd3;

  typedef enum logic [STAT_W-1:0] {
    FS_OK      = 2'd0,
    FS_NO_CROP = 2'd1,
    FS_RANGE   = 2'd2
  } crtp_fstat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_EVAL,
    S_DIV,
    S_ADDR,
    S_READ,
    S_DONE
  } crtp_state_t;

  typedef struct packed {
    logic load;       // write the accepted pixel into the crop store
    logic capture;    // latch the accepted fetch coordinates
    logic prod_en;    // register crop area, dimension check and numerators
    logic eval_en;    // register fetch status and plane index
    logic div_start;  // launch both nearest-pixel divisions
    logic take_quot;  // register the clamped source coordinates
    logic addr_en;    // register the crop store address
    logic read_en;    // read the crop store
    logic out_load;   // load the result register
  } crtp_cmd_t;

  typedef struct packed {
    logic eval_ok;    // fetch passes both checks
    logic div_done;   // both divisions finished
    logic out_free;   // result register can take a new result
  } crtp_sts_t;

endpackage

// ===== rtl/crtp_if.sv =====
// Valid/ready channel interfaces for the crop resize block: input items,
// result items and configuration writes. Depends on crtp_pkg.
interface crtp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic                        first_pixel;
  logic [crtp_pkg::CHAN_W-1:0] pixel_red;
  logic [crtp_pkg::CHAN_W-1:0] pixel_green;
  logic [crtp_pkg::CHAN_W-1:0] pixel_blue;
  logic [crtp_pkg::COORD_W-1:0] target_x;
  logic [crtp_pkg::COORD_W-1:0] target_y;

  modport source (output valid, action, first_pixel, pixel_red, pixel_green,
                  pixel_blue, target_x, target_y, input ready);
  modport sink   (input valid, action, first_pixel, pixel_red, pixel_green,
                  pixel_blue, target_x, target_y, output ready);
endinterface

interface crtp_out_if;
  logic                         valid;
  logic                         ready;
  logic [crtp_pkg::LEVEL_W-1:0] red_level;
  logic [crtp_pkg::LEVEL_W-1:0] green_level;
  logic [crtp_pkg::LEVEL_W-1:0] blue_level;
  logic [crtp_pkg::PLANE_W-1:0] plane_index;
  logic [crtp_pkg::STAT_W-1:0]  fetch_status;

  modport source (output valid, red_level, green_level, blue_level, plane_index,
                  fetch_status, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, plane_index,
                  fetch_status, output ready);
endinterface

interface crtp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [crtp_pkg::CFG_IDX_W-1:0] index;
  logic [crtp_pkg::DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/crtp_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on crtp_pkg for the operand widths.
module crtp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [crtp_pkg::NUM_W-1:0]  num,
  input  logic [crtp_pkg::DEN_W-1:0]  den,
  output logic [crtp_pkg::NUM_W-1:0]  quot,
  output logic                        done
);
  import crtp_pkg::*;

  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       diff;
  logic                 ge;

  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      cnt_nxt  = DIV_CNT_W'(NUM_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign quot = quo_r;
  assign done = done_r;

endmodule

// ===== rtl/crtp_dp.sv =====
// Datapath of the crop resize block: configuration registers, crop store,
// nearest-pixel dividers, address arithmetic and the result register.
// Depends on crtp_pkg and crtp_div.
module crtp_dp #(
  parameter int MAX_DIMENSION   = crtp_pkg::MAX_DIMENSION_DEF,
  parameter int MAX_CROP_PIXELS = crtp_pkg::MAX_CROP_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  crtp_pkg::crtp_cmd_t            cmd,
  output crtp_pkg::crtp_sts_t            sts,
  input  logic                           cfg_we,
  input  logic [crtp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crtp_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_first,
  input  logic [crtp_pkg::CHAN_W-1:0]    in_red,
  input  logic [crtp_pkg::CHAN_W-1:0]    in_green,
  input  logic [crtp_pkg::CHAN_W-1:0]    in_blue,
  input  logic [crtp_pkg::COORD_W-1:0]   in_x,
  input  logic [crtp_pkg::COORD_W-1:0]   in_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [crtp_pkg::LEVEL_W-1:0]   out_red,
  output logic [crtp_pkg::LEVEL_W-1:0]   out_green,
  output logic [crtp_pkg::LEVEL_W-1:0]   out_blue,
  output logic [crtp_pkg::PLANE_W-1:0]   out_plane,
  output logic [crtp_pkg::STAT_W-1:0]    out_status
);
  import crtp_pkg::*;

  localparam int CNT_W = $clog2(MAX_CROP_PIXELS + 1);
  localparam int AW    = $clog2(MAX_CROP_PIXELS);

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    return (d != '0) && (32'(d) <= MAX_DIMENSION);
  endfunction

  // Configuration.
  logic [DIM_W-1:0] cw_r, ch_r, tw_r, th_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= '0;
      ch_r <= '0;
      tw_r <= '0;
      th_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CROP_W:   cw_r <= cfg_data;
        REG_CROP_H:   ch_r <= cfg_data;
        REG_TARGET_W: tw_r <= cfg_data;
        REG_TARGET_H: th_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Crop store and fill count.
  logic [PIX_W-1:0] mem [MAX_CROP_PIXELS];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             full;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  assign full    = (32'(count_r) >= MAX_CROP_PIXELS);
  assign wr_en   = cmd.load && (in_first || !full);
  assign wr_addr = in_first ? '0 : count_r[AW-1:0];

  always_comb begin
    count_nxt = count_r;
    if (cmd.load) begin
      if (in_first) begin
        count_nxt = CNT_W'(1);
      end else if (!full) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_red, in_green, in_blue};
    end
  end

  // Fetch pipeline registers.
  logic [COORD_W-1:0] tx_r, ty_r;
  logic               dims_ok_r;
  logic [PROD_W-1:0]  prod_r;
  logic [NUM_W-1:0]   num_x_r, num_y_r;
  crtp_fstat_t        status_r, eval_stat;
  logic [IDX_W-1:0]   idx_r;
  logic [DIM_W-1:0]   sx_r, sy_r;
  logic [AW-1:0]      addr_r;
  logic [PIX_W-1:0]   rd_r;
  logic               no_crop, off_range;

  assign no_crop   = !dims_ok_r || (32'(count_r) < 32'(prod_r));
  assign off_range = ({1'b0, tx_r} >= tw_r) || ({1'b0, ty_r} >= th_r);

  always_comb begin
    if (no_crop) begin
      eval_stat = FS_NO_CROP;
    end else if (off_range) begin
      eval_stat = FS_RANGE;
    end else begin
      eval_stat = FS_OK;
    end
  end

  // Nearest source row and column: floor((2t+1)*src / (2*tgt)).
  logic [NUM_W-1:0] qx, qy;
  logic             dx, dy;
  logic [DIM_W-1:0] lim_x, lim_y;

  assign lim_x = cw_r - DIM_W'(1);
  assign lim_y = ch_r - DIM_W'(1);

  crtp_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_x_r),
    .den   ({tw_r, 1'b0}),
    .quot  (qx),
    .done  (dx)
  );

  crtp_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_y_r),
    .den   ({th_r, 1'b0}),
    .quot  (qy),
    .done  (dy)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tx_r <= in_x;
      ty_r <= in_y;
    end
    if (cmd.prod_en) begin
      dims_ok_r <= dim_ok(cw_r) && dim_ok(ch_r) && dim_ok(tw_r) && dim_ok(th_r);
      prod_r    <= PROD_W'(cw_r) * PROD_W'(ch_r);
      num_x_r   <= NUM_W'({tx_r, 1'b1}) * NUM_W'(cw_r);
      num_y_r   <= NUM_W'({ty_r, 1'b1}) * NUM_W'(ch_r);
    end
    if (cmd.eval_en) begin
      status_r <= eval_stat;
      idx_r    <= IDX_W'(ty_r) * IDX_W'(tw_r) + IDX_W'(tx_r);
    end
    if (cmd.take_quot) begin
      sx_r <= (qx > NUM_W'(lim_x)) ? lim_x : qx[DIM_W-1:0];
      sy_r <= (qy > NUM_W'(lim_y)) ? lim_y : qy[DIM_W-1:0];
    end
    if (cmd.addr_en) begin
      addr_r <= AW'(PROD_W'(sy_r) * PROD_W'(cw_r) + PROD_W'(sx_r));
    end
    if (cmd.read_en) begin
      rd_r <= mem[addr_r];
    end
  end

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] red_r, green_r, blue_r;
  logic [PLANE_W-1:0] plane_r;
  logic [STAT_W-1:0]  stat_out_r;
  logic               ok;

  assign ok = (status_r == FS_OK);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // A byte times 257 is the byte repeated in both halves.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red_r      <= ok ? {2{rd_r[PIX_W-1 -: CHAN_W]}} : '0;
      green_r    <= ok ? {2{rd_r[2*CHAN_W-1 -: CHAN_W]}} : '0;
      blue_r     <= ok ? {2{rd_r[CHAN_W-1:0]}} : '0;
      plane_r    <= ok ? idx_r[PLANE_W-1:0] : '0;
      stat_out_r <= status_r;
    end
  end

  assign sts.eval_ok  = (eval_stat == FS_OK);
  assign sts.div_done = dx && dy;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_red    = red_r;
  assign out_green  = green_r;
  assign out_blue   = blue_r;
  assign out_plane  = plane_r;
  assign out_status = stat_out_r;

endmodule

// ===== rtl/crtp_ctrl.sv =====
// Controller of the crop resize block: sequences loads and fetches and
// drives the datapath commands. Depends on crtp_pkg.
module crtp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_ready,
  input  crtp_pkg::crtp_sts_t sts,
  output crtp_pkg::crtp_cmd_t cmd
);
  import crtp_pkg::*;

  crtp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_FETCH) begin
            cmd.capture = 1'b1;
            state_nxt   = S_PROD;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_PROD: begin
        cmd.prod_en = 1'b1;
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval_en = 1'b1;
        if (sts.eval_ok) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.take_quot = 1'b1;
          state_nxt     = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.addr_en = 1'b1;
        state_nxt   = S_READ;
      end
      S_READ: begin
        cmd.read_en = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/crop_resize_to_planar.sv =====
// Top level of the crop-to-planar nearest-neighbor resize block.
// Depends on crtp_pkg, the channel interfaces, crtp_ctrl, crtp_dp, assert_macros.svh.
//
//   Channel   Dir   Transfer carries
//   in_ch     in    action, first_pixel, RGB bytes, target x and y
//   out_ch    out   three Q0.16 levels, plane index, fetch status
//   cfg_ch    in    register index and 10-bit dimension value
//
// A load is written to the crop store in the cycle it is accepted, unless the store
// is full and it does not restart; loads stream at one per cycle while no fetch is
// in progress and return nothing. A fetch that passes its checks goes from transfer
// to loaded result through the area and numerator products, the check, 20 steps of
// the two restoring dividers running side by side, address, store read and output;
// one that fails goes from the check to output. The next item is accepted in the
// cycle after its result has been loaded into the output register.
// Reset is synchronous and active low; the crop store is not cleared.
// A stalled result waits in the output register while new items are taken;
// a second result waits in the controller until that register frees up.
`include "assert_macros.svh"

module crop_resize_to_planar #(
  parameter int MAX_DIMENSION   = crtp_pkg::MAX_DIMENSION_DEF,
  parameter int MAX_CROP_PIXELS = crtp_pkg::MAX_CROP_PIXELS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  crtp_in_if.sink      in_ch,
  crtp_out_if.source   out_ch,
  crtp_cfg_if.sink     cfg_ch
);
  import crtp_pkg::*;

  crtp_cmd_t cmd;
  crtp_sts_t sts;
  logic      in_ready;

  // Configuration writes are taken at any time; the user writes only while idle.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  crtp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  crtp_dp #(
    .MAX_DIMENSION   (MAX_DIMENSION),
    .MAX_CROP_PIXELS (MAX_CROP_PIXELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_ch.valid && cfg_ch.ready),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .in_first   (in_ch.first_pixel),
    .in_red     (in_ch.pixel_red),
    .in_green   (in_ch.pixel_green),
    .in_blue    (in_ch.pixel_blue),
    .in_x       (in_ch.target_x),
    .in_y       (in_ch.target_y),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_red    (out_ch.red_level),
    .out_green  (out_ch.green_level),
    .out_blue   (out_ch.blue_level),
    .out_plane  (out_ch.plane_index),
    .out_status (out_ch.fetch_status)
  );

  // A result only appears after the controller has loaded the output register.
  `CRTP_ASSERT_RST(a_valid_load, clk, rst_n, $rose(out_ch.valid) |-> $past(cmd.out_load), "unloaded")
  // The output register is never overwritten while it still holds a result.
  `CRTP_ASSERT_RST(a_load_when_free, clk, rst_n, cmd.out_load |-> sts.out_free, "result overwritten")
  // Starting the dividers clears their done flag in the next cycle.
  `CRTP_ASSERT_RST(a_div_restart, clk, rst_n, cmd.div_start |=> !sts.div_done, "stale divider result")
  // Reset empties the result register.
  `CRTP_ASSERT(a_reset_empty, clk, !rst_n |=> !out_ch.valid, "result valid after reset")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for crop_resize_to_planar: loads crops, resizes them by fetches
// and checks each result against a bit-exact predictor. Needs crtp_pkg and crtp_if.sv.
module tb;
  import crtp_pkg::*;

  // The block is built with a small crop store so that the full store is reached
  // with a few hundred loads.
  localparam int          TB_CROP_PIXELS = 512;
  // The bench gives up after this many cycles. The slowest correct run fills the
  // whole crop store once and does a few thousand stalled fetches, well under this.
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  // Idle cycles allowed after the last result before a register is written or
  // the run ends. This is longer than a whole fetch takes.
  localparam int unsigned SETTLE_CYCLES = 30;

  // One expected fetch result, field for field as it leaves the block.
  typedef struct {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [PLANE_W-1:0] plane;
    crtp_fstat_t        status;
  } fetch_result_t;

  logic clk;
  logic rst_n;

  crtp_in_if  in_if();
  crtp_out_if out_if();
  crtp_cfg_if cfg_if();

  crop_resize_to_planar #(
    .MAX_CROP_PIXELS (TB_CROP_PIXELS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // This is the bench's own copy of the block state. The crop pixels are packed
  // R, G, B from the top byte down. The four dimensions mirror the registers.
  logic [PIX_W-1:0] crop_copy [TB_CROP_PIXELS];
  int unsigned      pixels_loaded;
  int unsigned      src_w, src_h, dst_w, dst_h;

  // Fetch results still owed by the block, oldest first.
  fetch_result_t    expected_pixels[$];

  // These counters feed the summary and the final verdict.
  int unsigned      cycle_count;
  int unsigned      failures;
  int unsigned      items_sent;
  int unsigned      loads_sent;
  int unsigned      fetches_sent;
  int unsigned      results_checked;
  int unsigned      reg_writes;

  // While this is set, neither the sender nor the result sink inserts gaps.
  bit               quiet;

  // The clock has a period of 2 ns.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // This is the watchdog. A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_pixels.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // This picks a gap length. Most gaps are zero or short and a few are long.
  // The sender and the result sink both use it.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit dim_usable(int unsigned d);
    return d != 0 && d <= MAX_DIMENSION_DEF;
  endfunction

  // This finds the nearest source coordinate for target coordinate t. It takes
  // the floor of (2t+1)*src / (2*dst) and clamps it to the last source pixel.
  // All of it is exact integer math.
  function automatic int unsigned nearest_src(int unsigned t, int unsigned src,
                                              int unsigned dst);
    int unsigned q;
    q = ((2 * t + 1) * src) / (2 * dst);
    return (q > src - 1) ? src - 1 : q;
  endfunction

  // A load restarts the count when asked, then fills the next free entry. Once
  // the store is full, loads that do not restart are dropped.
  function automatic void store_pixel(logic first, logic [CHAN_W-1:0] r,
                                      logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
    if (first) pixels_loaded = 0;
    if (pixels_loaded < TB_CROP_PIXELS) begin
      crop_copy[pixels_loaded] = {r, g, b};
      pixels_loaded++;
    end
  endfunction

  // This computes what a fetch of target pixel (x,y) returns under the current
  // registers and crop contents. The dimension and crop length check wins over
  // the coordinate range check.
  function automatic fetch_result_t resize_lookup(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
    fetch_result_t     res;
    longint unsigned   area;
    int unsigned       sx, sy;
    logic [PIX_W-1:0]  px;
    res.red    = '0;
    res.green  = '0;
    res.blue   = '0;
    res.plane  = '0;
    area = longint'(src_w) * longint'(src_h);
    if (!dim_usable(src_w) || !dim_usable(src_h) || !dim_usable(dst_w) ||
        !dim_usable(dst_h) || pixels_loaded < area) begin
      res.status = FS_NO_CROP;
    end else if (x >= dst_w || y >= dst_h) begin
      res.status = FS_RANGE;
    end else begin
      sy = nearest_src(y, src_h, dst_h);
      sx = nearest_src(x, src_w, dst_w);
      // The address is always below the loaded count here, so the entry was written.
      px = crop_copy[sy * src_w + sx];
      res.red    = 16'(px[23:16]) * 16'd257;
      res.green  = 16'(px[15:8]) * 16'd257;
      res.blue   = 16'(px[7:0]) * 16'd257;
      res.plane  = PLANE_W'(y * dst_w + x);
      res.status = FS_OK;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // This sends one item on the input channel and updates the predictor at the
  // moment the transfer happens. Valid is left high on return. A call that
  // follows with no gap keeps it high, so the next item goes back to back.
  task automatic send_item(input logic action, input logic first,
                           input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                           input logic [CHAN_W-1:0] b,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.action      <= action;
    in_if.first_pixel <= first;
    in_if.pixel_red   <= r;
    in_if.pixel_green <= g;
    in_if.pixel_blue  <= b;
    in_if.target_x    <= x;
    in_if.target_y    <= y;
    in_if.valid       <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    if (action == ACT_LOAD) begin
      store_pixel(first, r, g, b);
      loads_sent++;
    end else begin
      expected_pixels.insert(expected_pixels.size(), resize_lookup(x, y));
      fetches_sent++;
    end
  endtask

  // A load carries random coordinates and a fetch carries random color bytes.
  // The block must ignore the fields that do not apply.
  task automatic send_load(input logic first, input logic [CHAN_W-1:0] r,
                           input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
    send_item(ACT_LOAD, first, r, g, b, 9'($urandom), 9'($urandom));
  endtask

  task automatic send_fetch(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    send_item(ACT_FETCH, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), x, y);
  endtask

  // This loads n random pixels. The first one restarts the store if asked.
  task automatic load_random_crop(input int unsigned n, input bit restart);
    int unsigned i;
    for (i = 0; i < n; i++)
      send_load(restart && i == 0, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // This holds the sender back until every owed result has arrived, then idles
  // for tail_cycles more. It always lets at least one edge pass after dropping
  // valid, so valid is never dropped and raised again in one step.
  task automatic drain_results(input int unsigned tail_cycles);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (tail_cycles) @(posedge clk);
  endtask

  // This writes one register. Valid stays high so that several writes can go
  // back to back. configure() drops it after the last write.
  task automatic write_dim(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    reg_writes++;
    case (idx)
      REG_CROP_W:   src_w = value;
      REG_CROP_H:   src_h = value;
      REG_TARGET_W: dst_w = value;
      REG_TARGET_H: dst_h = value;
      default: ;
    endcase
  endtask

  // The registers are only changed while the block is idle. The sender waits
  // for the last result, then for the settle time, then writes all four.
  task automatic configure(input int unsigned cw, input int unsigned ch,
                           input int unsigned tw, input int unsigned th);
    drain_results(SETTLE_CYCLES);
    write_dim(REG_CROP_W,   DIM_W'(cw));
    write_dim(REG_CROP_H,   DIM_W'(ch));
    write_dim(REG_TARGET_W, DIM_W'(tw));
    write_dim(REG_TARGET_H, DIM_W'(th));
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // The result sink stalls for random stretches and accepts in between.
  // The gaps fall at random points in the block's fetch.
  initial begin : result_sink
    int unsigned n;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = idle_gap();
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      n = $urandom_range(1, 24);
      repeat (n) @(posedge clk);
    end
  end

  // Each result transfer is compared with the oldest expectation. The values
  // are sampled at the edge, so they are the ones the block presented.
  always @(posedge clk) begin
    fetch_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_pixels.size() == 0) begin
        if (failures < 10)
          $display("Result with none expected at cycle %0d: r=%h g=%h b=%h idx=%0d st=%0d",
                   cycle_count, out_if.red_level, out_if.green_level, out_if.blue_level,
                   out_if.plane_index, out_if.fetch_status);
        failures++;
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (out_if.red_level !== want.red || out_if.green_level !== want.green ||
            out_if.blue_level !== want.blue || out_if.plane_index !== want.plane ||
            out_if.fetch_status !== want.status) begin
          if (failures < 10)
            $display("Mismatch on result %0d: expected r=%h g=%h b=%h idx=%0d st=%0d, %s",
                     results_checked, want.red, want.green, want.blue, want.plane,
                     want.status,
                     $sformatf("got r=%h g=%h b=%h idx=%0d st=%0d", out_if.red_level,
                               out_if.green_level, out_if.blue_level,
                               out_if.plane_index, out_if.fetch_status));
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All dimensions are zero right after reset, so every fetch must report a
  // missing crop. A load in this state must not change that.
  task automatic test_unconfigured();
    send_fetch(9'd0, 9'd0);
    send_fetch(9'd511, 9'd511);
    send_load(1'b1, 8'hFF, 8'h00, 8'hFF);
    send_fetch(9'd0, 9'd0);
  endtask

  // This is a small hand-made crop with extreme colors. It covers both corners,
  // both range checks, a crop cut short by a restart, and dimensions that are
  // zero or above the maximum.
  task automatic test_directed_cases();
    configure(3, 2, 5, 4);
    send_load(1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_load(1'b0, 8'h00, 8'h00, 8'h00);
    send_load(1'b0, 8'hFF, 8'h00, 8'h00);
    send_load(1'b0, 8'h00, 8'hFF, 8'h00);
    send_load(1'b0, 8'h00, 8'h00, 8'hFF);
    send_load(1'b0, 8'h80, 8'h01, 8'h7F);
    send_fetch(9'd0, 9'd0);
    send_fetch(9'd4, 9'd3);
    send_fetch(9'd2, 9'd1);
    send_fetch(9'd5, 9'd0);      // one column past the target width
    send_fetch(9'd0, 9'd4);      // one row past the target height
    send_fetch(9'd511, 9'd511);
    // A restart leaves one pixel, too few for a 3x2 crop.
    send_load(1'b1, 8'h12, 8'h34, 8'h56);
    send_fetch(9'd1, 9'd1);
    configure(513, 2, 5, 4);
    send_fetch(9'd0, 9'd0);
    configure(1, 1, 0, 4);
    send_fetch(9'd0, 9'd0);
    configure(1, 1, 5, 1023);
    send_fetch(9'd0, 9'd0);
  endtask

  // These are the largest dimensions: a one-row crop 512 wide, a one-column crop
  // 512 high, and the largest target, which gives the top plane index.
  task automatic test_dimension_extremes();
    configure(512, 1, 512, 512);
    load_random_crop(512, 1'b1);
    send_fetch(9'd0, 9'd0);
    send_fetch(9'd511, 9'd511);
    send_fetch(9'd511, 9'd0);
    send_fetch(9'd0, 9'd511);
    repeat (4) send_fetch(9'($urandom), 9'($urandom));
    // Downscale the same crop to a single pixel.
    configure(512, 1, 1, 1);
    send_fetch(9'd0, 9'd0);
    send_fetch(9'd1, 9'd0);
    // The same 512 pixels are read back as a one-column crop.
    configure(1, 512, 1, 512);
    send_fetch(9'd0, 9'd0);
    send_fetch(9'd0, 9'd511);
    send_fetch(9'd1, 9'd100);
    repeat (4) send_fetch(9'd0, 9'($urandom));
    // A single pixel is blown up to the full target.
    configure(1, 1, 512, 512);
    load_random_crop(1, 1'b1);
    send_fetch(9'd511, 9'd511);
    send_fetch(9'd0, 9'd0);
  endtask

  // This fills the whole crop store and pushes a few more loads, which must be
  // dropped. A crop exactly as large as the store reads back its first and last pixel.
  // A crop one row larger counts as short. A restart after saturation works again.
  task automatic test_store_full();
    quiet = 1'b1;
    configure(16, 32, 512, 512);
    load_random_crop(TB_CROP_PIXELS, 1'b1);
    send_load(1'b0, 8'hA5, 8'h5A, 8'hC3);
    send_load(1'b0, 8'h00, 8'hFF, 8'h00);
    send_load(1'b0, 8'hFF, 8'h00, 8'hFF);
    quiet = 1'b0;
    send_fetch(9'd0, 9'd0);
    send_fetch(9'd511, 9'd511);
    send_fetch(9'd255, 9'd255);
    repeat (8) send_fetch(9'($urandom), 9'($urandom));
    configure(512, 1, 3, 7);
    send_fetch(9'd2, 9'd6);
    repeat (6) send_fetch(9'($urandom_range(0, 2)), 9'($urandom_range(0, 6)));
    configure(512, 2, 4, 4);
    send_fetch(9'd0, 9'd0);
    send_load(1'b1, 8'h3C, 8'hC3, 8'h99);
    configure(1, 1, 1, 1);
    send_fetch(9'd0, 9'd0);
  endtask

  // Random crop dimensions. They are kept small so that each sequence loads
  // only a few pixels.
  function automatic int unsigned crop_dim();
    return ($urandom_range(0, 9) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 16);
  endfunction

  function automatic int unsigned target_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 12);
    if (r < 90) return $urandom_range(1, 512);
    return (r < 95) ? 1 : 512;
  endfunction

  // Most sequences are well formed. The registers are set, a full crop is loaded
  // from a restart, and a run of fetches follows, mostly in range. The rest are
  // broken: a dimension is unusable, the crop is short or appended to an old one,
  // stray loads or restarts fall between fetches, or coordinates are random.
  task automatic test_random_sequences(input int unsigned item_goal);
    int unsigned first_item, cw, ch, tw, th, n_loads, n_fetch, i, mode;
    logic [COORD_W-1:0] x, y;
    first_item = items_sent;
    while (items_sent - first_item < item_goal) begin
      cw = crop_dim();
      ch = crop_dim();
      tw = target_dim();
      th = target_dim();
      case ($urandom_range(0, 11))
        0: cw = $urandom_range(0, 1) ? 0 : $urandom_range(513, 1023);
        1: ch = $urandom_range(0, 1) ? 0 : $urandom_range(513, 1023);
        2: tw = $urandom_range(0, 1) ? 0 : $urandom_range(513, 1023);
        3: th = $urandom_range(0, 1) ? 0 : $urandom_range(513, 1023);
        default: ;
      endcase
      configure(cw, ch, tw, th);
      quiet = ($urandom_range(0, 7) == 0);
      // An unusable crop width or height can make the area huge, so loads are capped at 32 then.
      n_loads = cw * ch;
      if (!dim_usable(cw) || !dim_usable(ch)) n_loads = (n_loads > 32) ? 32 : n_loads;
      mode = $urandom_range(0, 9);
      if (mode == 0 && n_loads > 0)
        n_loads = $urandom_range(0, n_loads - 1);
      else if (mode >= 8)
        n_loads += $urandom_range(1, 3);
      // In mode one the pixels are appended to whatever is in the store.
      load_random_crop(n_loads, mode != 1);
      n_fetch = $urandom_range(4, 16);
      for (i = 0; i < n_fetch; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_load(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 24) == 0)
          drain_results(0);
        if ($urandom_range(0, 6) == 0) begin
          x = 9'($urandom);
          y = 9'($urandom);
        end else begin
          x = 9'($urandom_range(0, (tw == 0 || tw > 512) ? 511 : tw - 1));
          y = 9'($urandom_range(0, (th == 0 || th > 512) ? 511 : th - 1));
        end
        send_fetch(x, y);
      end
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Every block input gets a known value at time zero.
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.action       <= ACT_LOAD;
    in_if.first_pixel  <= 1'b0;
    in_if.pixel_red    <= '0;
    in_if.pixel_green  <= '0;
    in_if.pixel_blue   <= '0;
    in_if.target_x     <= '0;
    in_if.target_y     <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_CROP_W;
    cfg_if.data        <= '0;
    cycle_count        = 0;
    failures           = 0;
    items_sent         = 0;
    loads_sent         = 0;
    fetches_sent       = 0;
    results_checked    = 0;
    reg_writes         = 0;
    quiet              = 1'b0;
    // The predictor starts from the reset state: no pixels and all dimensions zero.
    pixels_loaded      = 0;
    src_w              = 0;
    src_h              = 0;
    dst_w              = 0;
    dst_h              = 0;

    // Reset is held low and released on an edge.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unconfigured();
    test_directed_cases();
    test_dimension_extremes();
    test_store_full();
    test_random_sequences(700);

    // Wait for the last results, then give the block time to show any extra one.
    drain_results(SETTLE_CYCLES + 10);
    if (expected_pixels.size() != 0) failures++;

    $display("Sent %0d loads and %0d fetches, checked %0d results, wrote %0d registers.",
             loads_sent, fetches_sent, results_checked, reg_writes);
    $display("Covered corners, range and short-crop errors, bad dimensions, full store.");
    if (failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== crop_resize_to_planar.f =====
+incdir+rtl
rtl/crtp_pkg.sv
rtl/crtp_if.sv
rtl/crtp_div.sv
rtl/crtp_dp.sv
rtl/crtp_ctrl.sv
rtl/crop_resize_to_planar.sv
tb/tb.sv
